// ===== design/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  // Fixed field widths
  localparam int unsigned CFG_W   = 10;   // region bounds, start_res
  localparam int unsigned SIZE_W  = 11;   // size, free_start
  localparam int unsigned POS_W   = 12;   // scan / mark positions (max 4095)
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_RT_FIRST   = 2'd0,
    REG_RT_LAST    = 2'd1,
    REG_USER_FIRST = 2'd2,
    REG_USER_LAST  = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RT_FIRST_RST   = 10'd0;
  localparam logic [CFG_W-1:0] RT_LAST_RST    = 10'd63;
  localparam logic [CFG_W-1:0] USER_FIRST_RST = 10'd64;
  localparam logic [CFG_W-1:0] USER_LAST_RST  = 10'd1023;

  // Request opcodes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== design/bfa_if.sv =====
`default_nettype none

interface bfa_req_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic                               priority_req;
  logic [bfa_pkg::SIZE_W-1:0]         size;
  logic signed [bfa_pkg::SIZE_W-1:0]  free_start;

  modport source (output valid, op, priority_req, size, free_start, input ready);
  modport sink   (input valid, op, priority_req, size, free_start, output ready);
endinterface

interface bfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bfa_pkg::CFG_W-1:0]   start_res;

  modport source (output valid, ok, start_res, input ready);
  modport sink   (input valid, ok, start_res, output ready);
endinterface

`default_nettype wire

// ===== design/best_fit_block_allocator.sv =====
`default_nettype none

// Channel   Dir  Beat payload                               Handshake
// req       in   op, priority_req, size, free_start         valid/ready
// rsp       out  ok, start_res                              valid/ready
// apb       in   4 region bound registers at 0x0..0xC       psel/penable/pwrite, pready=1
//
// Reset: the occupancy map is swept clear, one entry a cycle, with req.ready low.
// Register writes are taken anytime. Allocate: prime the map read, read each position
// from first through last+1 (exact fit exits early), on a grant mark each block, then
// post the result. Free: clear each block, then post the result. One request in
// flight; the next is taken while the result waits in rsp, a stalled rsp holds the post.

module best_fit_block_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire                            clk,
  input  wire                            rst,
  bfa_req_if.sink                        req,
  bfa_rsp_if.source                      rsp,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [bfa_pkg::PADDR_W-1:0]    paddr,
  input  wire  [bfa_pkg::PDATA_W-1:0]    pwdata,
  output logic [bfa_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import bfa_pkg::*;

  localparam int AW      = $clog2(NUM_BLOCKS);
  localparam int CAP_INT = (NUM_BLOCKS - 1 > 2047) ? 2047 : NUM_BLOCKS - 1;
  localparam logic [POS_W-1:0] LAST_CAP = POS_W'(CAP_INT);
  localparam logic [AW-1:0]    CLR_END  = AW'(NUM_BLOCKS - 1);

  // ---------------------------------------------------------------------------
  // Region registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] rt_first, rt_last, user_first, user_last;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_first   <= RT_FIRST_RST;
      rt_last    <= RT_LAST_RST;
      user_first <= USER_FIRST_RST;
      user_last  <= USER_LAST_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_RT_FIRST:   rt_first   <= pwdata[CFG_W-1:0];
        REG_RT_LAST:    rt_last    <= pwdata[CFG_W-1:0];
        REG_USER_FIRST: user_first <= pwdata[CFG_W-1:0];
        REG_USER_LAST:  user_last  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RT_FIRST:   prdata = PDATA_W'(rt_first);
      REG_RT_LAST:    prdata = PDATA_W'(rt_last);
      REG_USER_FIRST: prdata = PDATA_W'(user_first);
      REG_USER_LAST:  prdata = PDATA_W'(user_last);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Occupancy map: 1 bit per block, one write and one registered read per cycle
  // ---------------------------------------------------------------------------
  logic          occ_mem [NUM_BLOCKS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rdata <= occ_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t             state, state_next;
  logic [AW-1:0]      clr_idx, clr_idx_next;
  logic [POS_W-1:0]   rd_pos, rd_pos_next;       // read issue pointer
  logic               eval_valid, eval_valid_next;
  logic [POS_W-1:0]   eval_pos, eval_pos_next;   // position whose bit is in mem_rdata
  logic [SIZE_W-1:0]  run_len, run_len_next;
  logic [POS_W-1:0]   run_start, run_start_next;
  logic               best_valid, best_valid_next;
  logic [POS_W-1:0]   best_start, best_start_next;
  logic [SIZE_W-1:0]  best_left, best_left_next;
  logic [POS_W-1:0]   scan_last, scan_last_next;
  logic [SIZE_W-1:0]  req_size, req_size_next;
  logic [POS_W-1:0]   mark_pos, mark_pos_next;
  logic [SIZE_W-1:0]  mark_cnt, mark_cnt_next;
  logic               mark_val, mark_val_next;
  logic               res_ok, res_ok_next;
  logic [CFG_W-1:0]   res_start, res_start_next;
  logic               out_valid, out_valid_next;
  logic               out_ok, out_ok_next;
  logic [CFG_W-1:0]   out_start, out_start_next;

  // request decode
  logic [CFG_W-1:0]   sel_first, sel_last;
  logic [POS_W-1:0]   last_eff;
  // scan datapath
  logic               issue;
  logic               is_free;
  logic               fits;
  logic [SIZE_W-1:0]  left;
  logic               scan_end;
  logic               exact;

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.ok       = out_ok;
  assign rsp.start_res = out_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      eval_valid <= eval_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos     <= rd_pos_next;
    eval_pos   <= eval_pos_next;
    run_len    <= run_len_next;
    run_start  <= run_start_next;
    best_valid <= best_valid_next;
    best_start <= best_start_next;
    best_left  <= best_left_next;
    scan_last  <= scan_last_next;
    req_size   <= req_size_next;
    mark_pos   <= mark_pos_next;
    mark_cnt   <= mark_cnt_next;
    mark_val   <= mark_val_next;
    res_ok     <= res_ok_next;
    res_start  <= res_start_next;
    out_ok     <= out_ok_next;
    out_start  <= out_start_next;
  end

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    rd_pos_next     = rd_pos;
    eval_valid_next = 1'b0;
    eval_pos_next   = eval_pos;
    run_len_next    = run_len;
    run_start_next  = run_start;
    best_valid_next = best_valid;
    best_start_next = best_start;
    best_left_next  = best_left;
    scan_last_next  = scan_last;
    req_size_next   = req_size;
    mark_pos_next   = mark_pos;
    mark_cnt_next   = mark_cnt;
    mark_val_next   = mark_val;
    res_ok_next     = res_ok;
    res_start_next  = res_start;
    out_valid_next  = out_valid;
    out_ok_next     = out_ok;
    out_start_next  = out_start;

    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = 1'b0;
    mem_raddr = AW'(rd_pos);

    sel_first = req.priority_req ? user_first : rt_first;
    sel_last  = req.priority_req ? user_last  : rt_last;
    last_eff  = (POS_W'(sel_last) > LAST_CAP) ? LAST_CAP : POS_W'(sel_last);

    issue    = (rd_pos <= scan_last + POS_W'(1));
    is_free  = (eval_pos <= scan_last) && !mem_rdata;
    fits     = (run_len >= req_size);
    left     = run_len - req_size;
    scan_end = (eval_pos == scan_last + POS_W'(1));
    exact    = 1'b0;

    if (rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        mem_wdata    = 1'b0;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == CLR_END) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          req_size_next  = req.size;
          res_ok_next    = 1'b0;
          res_start_next = '0;
          if (op_t'(req.op) == OP_ALLOC) begin
            scan_last_next  = last_eff;
            rd_pos_next     = POS_W'(sel_first);
            run_len_next    = '0;
            run_start_next  = '0;
            best_valid_next = 1'b0;
            best_start_next = '0;
            best_left_next  = '0;
            if (req.size == '0 || POS_W'(sel_first) > last_eff) begin
              state_next = ST_FINISH;
            end else begin
              state_next = ST_SCAN;
            end
          end else begin
            // free: negative start skips the whole request
            mark_pos_next = POS_W'(req.free_start);
            mark_cnt_next = req.size;
            mark_val_next = 1'b0;
            if (req.free_start[SIZE_W-1]) begin
              state_next = ST_FINISH;
            end else begin
              res_ok_next = 1'b1;
              state_next  = ST_MARK;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue side: one map read per cycle
        if (issue) begin
          rd_pos_next = rd_pos + POS_W'(1);
        end
        eval_valid_next = issue;
        eval_pos_next   = rd_pos;
        // evaluate side: run tracking and best-fit compare
        if (eval_valid) begin
          if (is_free) begin
            if (run_len == '0) begin
              run_start_next = eval_pos;
            end
            run_len_next = run_len + SIZE_W'(1);
          end else begin
            if (fits && (!best_valid || left < best_left)) begin
              best_valid_next = 1'b1;
              best_left_next  = left;
              best_start_next = run_start;
            end
            exact        = fits && (left == '0);
            run_len_next = '0;
          end
          if (exact || scan_end) begin
            eval_valid_next = 1'b0;
            mark_pos_next   = best_start_next;
            mark_cnt_next   = req_size;
            mark_val_next   = 1'b1;
            if (best_valid_next) begin
              res_ok_next    = 1'b1;
              res_start_next = best_start_next[CFG_W-1:0];
              state_next     = ST_MARK;
            end else begin
              state_next = ST_FINISH;
            end
          end
        end
      end

      ST_MARK: begin
        if (mark_cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          // blocks past the end of memory are skipped
          mem_we        = (32'(mark_pos) < 32'(NUM_BLOCKS));
          mem_waddr     = AW'(mark_pos);
          mem_wdata     = mark_val;
          mark_pos_next = mark_pos + POS_W'(1);
          mark_cnt_next = mark_cnt - SIZE_W'(1);
        end
      end

      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_ok_next    = res_ok;
          out_start_next = res_start;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fail_start_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_start == '0))
    else $error("failed result carries nonzero start");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req.ready)
    else $error("request taken during map clear");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_pos <= scan_last + POS_W'(2)))
    else $error("scan pointer ran past region");

  a_mark_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && mark_val && mark_cnt != '0) |-> (mark_pos <= scan_last))
    else $error("allocation marks outside region");

endmodule

`default_nettype wire

// ===== verif/tb_best_fit_block_allocator.sv =====
`default_nettype none

module tb_best_fit_block_allocator;
  import bfa_pkg::*;

  localparam int NBLK = 1024;
  // Slowest legal beat is a whole-memory scan plus a whole-memory mark.
  // The limit covers ~560 beats of that, plus stalls, times a margin.
  localparam longint CYCLE_LIMIT = 5_000_000;

  typedef struct {
    op_t                      op;
    logic                     prio;
    logic [SIZE_W-1:0]        len;
    logic signed [SIZE_W-1:0] fstart;
  } request_t;

  typedef struct {
    logic             ok;
    logic [CFG_W-1:0] at;
  } grant_t;

  typedef struct {
    int unsigned at;
    int unsigned len;
  } run_t;

  logic clk;
  logic rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  best_fit_block_allocator #(
    .NUM_BLOCKS(NBLK)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow of the occupancy map and of the region bound registers.
  bit               occ_map [NBLK];
  logic [CFG_W-1:0] rt_lo, rt_hi, usr_lo, usr_hi;

  grant_t pending_grants[$];   // predicted results, oldest first
  run_t   live_runs[$];        // granted runs not yet freed by the stimulus

  int errors;
  int beats_sent;
  int grants_made;
  int frees_sent;
  int reg_writes;
  int gap_pct;                 // sender idle chance per beat, percent
  int stall_pct;               // receiver stall chance per cycle, percent
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_grants.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: ready toggles at the falling edge with the phase's stall rate.
  always @(negedge clk) begin
    rsp_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checker: every rsp beat is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $error("rsp beat with nothing outstanding: ok=%0d start_res=%0d",
               rsp_ch.ok, rsp_ch.start_res);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (rsp_ch.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
          errors++;
        end
        if (rsp_ch.start_res !== want.at) begin
          $error("start_res: expected %0d, got %0d", want.at, rsp_ch.start_res);
          errors++;
        end
      end
    end
  end

  // Smallest-leftover search over the shadow map. Scans one past the region
  // end so the final run is closed; first exact run ends the search; strict
  // '<' keeps the earliest run on equal leftover.
  function automatic bit pick_run(input int unsigned need, input bit prio,
                                  output int unsigned start);
    int unsigned lo, hi, run, run_at, best_at, best_left, i;
    bit found, is_free;
    lo = prio ? usr_lo : rt_lo;
    hi = prio ? usr_hi : rt_hi;
    if (hi > NBLK - 1) hi = NBLK - 1;
    start = 0;
    found = 0;
    run = 0;
    run_at = 0;
    best_at = 0;
    best_left = 0;
    if (need == 0 || lo > hi) return 0;
    for (i = lo; i <= hi + 1; i++) begin
      is_free = (i <= hi) && !occ_map[i];
      if (is_free) begin
        if (run == 0) run_at = i;
        run++;
      end else begin
        if (run >= need) begin
          if (!found || run - need < best_left) begin
            found = 1;
            best_left = run - need;
            best_at = run_at;
          end
          if (run == need) break;
        end
        run = 0;
      end
    end
    if (!found) return 0;
    for (i = 0; i < need; i++) occ_map[best_at + i] = 1;
    start = best_at;
    return 1;
  endfunction

  // Applies one accepted request to the shadow state and returns its result.
  function automatic grant_t apply_request(input request_t r);
    grant_t g;
    int unsigned start, idx, i;
    g.ok = 0;
    g.at = '0;
    if (r.op == OP_ALLOC) begin
      if (pick_run(r.len, r.prio, start)) begin
        g.ok = 1;
        g.at = start[CFG_W-1:0];
        live_runs.push_back('{start, r.len});
        grants_made++;
      end
    end else begin
      // negative start: nothing was allocated, skip; otherwise clip at end
      if (!r.fstart[SIZE_W-1]) begin
        for (i = 0; i < r.len; i++) begin
          idx = r.fstart + i;
          if (idx < NBLK) occ_map[idx] = 0;
        end
        g.ok = 1;
      end
    end
    return g;
  endfunction

  function automatic request_t mk(input op_t op, input bit prio, input int len,
                                  input int fstart);
    request_t r;
    r.op = op;
    r.prio = prio;
    r.len = SIZE_W'(len);
    r.fstart = SIZE_W'(fstart);
    return r;
  endfunction

  // Sends one beat, idling first at the phase's rate; prediction is done at
  // acceptance so it sees the map exactly as the block does.
  task automatic send_beat(input request_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= r.op;
    req_ch.priority_req <= r.prio;
    req_ch.size         <= r.len;
    req_ch.free_start   <= r.fstart;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
    if (r.op == OP_FREE) frees_sent++;
    pending_grants.push_back(apply_request(r));
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic drain;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {22'($urandom()), val};   // upper bits are don't-care
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RT_FIRST:   rt_lo  = val;
      REG_RT_LAST:    rt_hi  = val;
      REG_USER_FIRST: usr_lo = val;
      REG_USER_LAST:  usr_hi = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== val) begin
      $error("prdata reg %0d: expected %0d, got %0d", idx, val, prdata[CFG_W-1:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regions(input int a, input int b, input int c, input int d);
    reg_write(REG_RT_FIRST, CFG_W'(a));
    reg_write(REG_RT_LAST, CFG_W'(b));
    reg_write(REG_USER_FIRST, CFG_W'(c));
    reg_write(REG_USER_LAST, CFG_W'(d));
  endtask

  // Mostly well-formed traffic: allocations and frees of runs that were
  // actually granted, plus some noise frees with arbitrary bounds.
  function automatic request_t random_request();
    request_t r;
    int pick, sz, k;
    pick = $urandom_range(0, 99);
    r = mk(OP_ALLOC, 1'($urandom_range(0, 1)), 1, int'($urandom_range(0, 1024)) - 1);
    if (pick < 50 || (pick < 85 && live_runs.size() == 0)) begin
      sz = $urandom_range(0, 99);
      if (sz < 3)       r.len = '0;
      else if (sz < 5)  r.len = SIZE_W'(NBLK);
      else if (sz < 15) r.len = SIZE_W'($urandom_range(1, 64));
      else              r.len = SIZE_W'($urandom_range(1, 12));
    end else if (pick < 85) begin
      k = $urandom_range(0, live_runs.size() - 1);
      r.op = OP_FREE;
      r.fstart = SIZE_W'(live_runs[k].at);
      r.len = SIZE_W'(live_runs[k].len);
      live_runs.delete(k);
    end else begin
      r.op = OP_FREE;
      r.fstart = ($urandom_range(0, 4) == 0) ? '1 : SIZE_W'($urandom_range(0, NBLK - 1));
      r.len = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, NBLK)
                                                  : $urandom_range(0, 32));
    end
    return r;
  endfunction

  // Reset register values: rt 0..63, user 64..1023.
  // Builds a fragmented real-time region to hit zero size, exact fit,
  // smallest leftover, equal-leftover tie, no fit, and the free corner cases.
  task automatic test_default_regions;
    send_beat(mk(OP_ALLOC, 0, 0, 0));        // zero size is rejected
    send_beat(mk(OP_ALLOC, 0, 8, 0));        // 0..7
    send_beat(mk(OP_ALLOC, 0, 4, 0));        // 8..11
    send_beat(mk(OP_ALLOC, 0, 8, 0));        // 12..19
    send_beat(mk(OP_ALLOC, 0, 4, -1));       // 20..23, free_start ignored
    send_beat(mk(OP_FREE, 1, 8, 0));         // priority ignored on free
    send_beat(mk(OP_FREE, 0, 8, 12));        // holes of 8, 8 and 40
    send_beat(mk(OP_ALLOC, 0, 5, 0));        // tie on leftover: earliest hole
    send_beat(mk(OP_ALLOC, 0, 3, 0));        // exact fit in the remainder
    send_beat(mk(OP_ALLOC, 0, 2, 0));        // best fit over the 40-block hole
    send_beat(mk(OP_ALLOC, 0, 41, 0));       // nothing fits
    send_beat(mk(OP_ALLOC, 1, NBLK, 0));     // larger than the user region
    send_beat(mk(OP_ALLOC, 1, 960, 1023));   // whole user region, exact
    send_beat(mk(OP_FREE, 0, 4, -1));        // negative start: skipped
    send_beat(mk(OP_FREE, 1, 0, 5));         // zero size free still ok
    send_beat(mk(OP_FREE, 0, 10, 1020));     // clipped at end of memory
    send_beat(mk(OP_FREE, 1, 1, 1023));
    send_beat(mk(OP_FREE, 0, NBLK, 0));      // clear all
    drain();
  endtask

  // Whole-memory region, single-block region, inverted (empty) region.
  task automatic test_region_extremes;
    set_regions(0, NBLK - 1, NBLK - 1, NBLK - 1);
    send_beat(mk(OP_ALLOC, 0, NBLK, 0));     // whole memory
    send_beat(mk(OP_ALLOC, 1, 1, 0));        // single block already taken
    send_beat(mk(OP_FREE, 0, 100, 1000));    // frees 1000..1023, rest clipped
    send_beat(mk(OP_ALLOC, 1, 1, 0));        // 1023
    send_beat(mk(OP_ALLOC, 0, 23, 0));       // exact hole 1000..1022
    send_beat(mk(OP_FREE, 0, NBLK, 0));
    drain();
    set_regions(NBLK - 1, 0, 0, 0);
    send_beat(mk(OP_ALLOC, 0, 1, 0));        // first after last: empty region
    send_beat(mk(OP_ALLOC, 1, 1, 0));
    send_beat(mk(OP_ALLOC, 1, 1, 0));        // single block now full
    send_beat(mk(OP_FREE, 0, 1, 0));
    drain();
  endtask

  // Random traffic under each idling pattern. Regions are kept narrow so
  // scans stay short, except the last phase which goes back to reset values.
  task automatic test_random_traffic;
    int gaps[4]   = '{0, 83, 0, 35};
    int stalls[4] = '{0, 0, 83, 35};
    int ph, n, lo, span;
    for (ph = 0; ph < 4; ph++) begin
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      if (ph == 3) begin
        set_regions(RT_FIRST_RST, RT_LAST_RST, USER_FIRST_RST, USER_LAST_RST);
      end else begin
        lo = $urandom_range(0, 900);
        span = $urandom_range(16, 123);
        reg_write(REG_RT_FIRST, CFG_W'(lo));
        reg_write(REG_RT_LAST, CFG_W'(lo + span));
        lo = $urandom_range(0, 900);
        span = $urandom_range(16, 123);
        reg_write(REG_USER_FIRST, CFG_W'(lo));
        reg_write(REG_USER_LAST, CFG_W'(lo + span));
      end
      for (n = 0; n < 130; n++) begin
        send_beat(random_request());
        // let the pipe run dry now and then
        if (n % 45 == 44) drain();
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.priority_req = 1'b0;
    req_ch.size = '0;
    req_ch.free_start = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (occ_map[i]) occ_map[i] = 0;
    rt_lo = RT_FIRST_RST;
    rt_hi = RT_LAST_RST;
    usr_lo = USER_FIRST_RST;
    usr_hi = USER_LAST_RST;
    errors = 0;
    beats_sent = 0;
    grants_made = 0;
    frees_sent = 0;
    reg_writes = 0;
    gap_pct = 0;
    stall_pct = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // DUT sweeps the map after reset; send_beat waits on ready for that.
    test_default_regions();
    test_region_extremes();
    test_random_traffic();

    repeat (20) @(posedge clk);
    $display("%0d requests (%0d frees, %0d grants), %0d register writes,",
             beats_sent, frees_sent, grants_made, reg_writes);
    $display("default, extreme and narrow regions under four idle patterns");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
